// ===== hw/rtl/hcbp_pkg.sv =====
// hcbp_pkg: shared constants, codes and types of the huffman code bit packer
// no dependencies; compile first
`default_nettype none

package hcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int NUM_SYMBOLS  = 256;

    localparam int FUNC_W   = 2;
    localparam int SYM_W    = 8;
    localparam int CODE_W   = 32;
    localparam int LEN_W    = 6;
    localparam int BYTE_W   = 8;
    localparam int PAD_W    = 4;
    localparam int TABLE_AW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_FINISH = 2'd2,
        FUNC_UNUSED = 2'd3
    } func_t;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

    typedef enum logic {
        PK_IDLE   = 1'b0,
        PK_ENCODE = 1'b1
    } pack_state_t;

    typedef struct packed {
        logic [CODE_W-1:0] word;
        logic [LEN_W-1:0]  len;
    } table_entry_t;

    // code word is left aligned: bit CODE_W-1 is the first code bit
    typedef struct packed {
        op_t               op;
        logic [CODE_W-1:0] word;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hcbp_if.sv =====
// hcbp_if: valid/ready channel interfaces for input items and result words
// depends on hcbp_pkg
`default_nettype none

interface hcbp_in_if;
    logic                         valid;
    logic                         ready;
    logic [hcbp_pkg::FUNC_W-1:0]  func;
    logic [hcbp_pkg::SYM_W-1:0]   symbol;
    logic [hcbp_pkg::CODE_W-1:0]  code_word;
    logic [hcbp_pkg::LEN_W-1:0]   code_len;

    modport source (output valid, output func, output symbol, output code_word,
                    output code_len, input ready);
    modport sink   (input valid, input func, input symbol, input code_word,
                    input code_len, output ready);
endinterface

interface hcbp_out_if;
    logic                         valid;
    logic                         ready;
    logic [hcbp_pkg::BYTE_W-1:0]  out_byte;
    logic [hcbp_pkg::PAD_W-1:0]   padding_bits;
    logic                         is_final;
    logic                         last;

    modport source (output valid, output out_byte, output padding_bits,
                    output is_final, output last, input ready);
    modport sink   (input valid, input out_byte, input padding_bits,
                    input is_final, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hcbp_front.sv =====
// hcbp_front: accepts input words, owns the code table, issues pack commands
// depends on hcbp_pkg and hcbp_if
`default_nettype none

module hcbp_front
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    hcbp_in_if.sink                       items,
    input  wire hcbp_pkg::queue_status_t  qstat,
    output logic                          push_valid,
    output hcbp_pkg::cmd_t                push_cmd
);

    hcbp_pkg::table_entry_t code_table [hcbp_pkg::NUM_SYMBOLS];

    logic                              accept;
    logic                              sym_ok;
    logic                              do_load;
    logic                              do_read;
    logic [hcbp_pkg::TABLE_AW-1:0]     idx;
    logic [hcbp_pkg::LEN_W-1:0]        sat_len;
    hcbp_pkg::table_entry_t            wr_entry;
    hcbp_pkg::table_entry_t            rd_reg;
    logic                              pend_valid_reg;
    logic                              pend_valid_next;
    hcbp_pkg::op_t                     pend_op_reg;
    hcbp_pkg::op_t                     pend_op_next;
    logic [hcbp_pkg::LEN_W:0]          align_sh;

    // room must cover the command still in flight from the table read
    assign items.ready = (int'(qstat.count) + int'(pend_valid_reg)) < hcbp_pkg::QUEUE_DEPTH;
    assign accept      = items.valid && items.ready;

    assign sym_ok  = int'(items.symbol) < hcbp_pkg::NUM_SYMBOLS;
    assign idx     = items.symbol[hcbp_pkg::TABLE_AW-1:0];
    assign do_load = accept && sym_ok && (items.func == hcbp_pkg::FUNC_LOAD);
    assign do_read = accept && sym_ok && (items.func == hcbp_pkg::FUNC_ENCODE);

    assign sat_len = (int'(items.code_len) > hcbp_pkg::MAX_CODE_LEN)
                   ? hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN) : items.code_len;
    assign wr_entry.word = items.code_word;
    assign wr_entry.len  = sat_len;

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            code_table[idx] <= wr_entry;
        end
        if (do_read)
        begin
            rd_reg <= code_table[idx];
        end
    end

    always_comb
    begin
        pend_valid_next = 1'b0;
        pend_op_next    = pend_op_reg;
        if (do_read)
        begin
            pend_valid_next = 1'b1;
            pend_op_next    = hcbp_pkg::OP_ENCODE;
        end
        else if (accept && (items.func == hcbp_pkg::FUNC_FINISH))
        begin
            pend_valid_next = 1'b1;
            pend_op_next    = hcbp_pkg::OP_FINISH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_op_reg    <= hcbp_pkg::OP_ENCODE;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_op_reg    <= pend_op_next;
        end
    end

    // left align the code so that bits above its length drop out
    assign align_sh = (hcbp_pkg::LEN_W + 1)'(hcbp_pkg::CODE_W)
                    - {1'b0, rd_reg.len};

    always_comb
    begin
        push_valid  = pend_valid_reg;
        push_cmd.op = pend_op_reg;
        if (pend_op_reg == hcbp_pkg::OP_ENCODE)
        begin
            push_cmd.word = rd_reg.word << align_sh;
            push_cmd.len  = rd_reg.len;
        end
        else
        begin
            push_cmd.word = '0;
            push_cmd.len  = '0;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hcbp_queue.sv =====
// hcbp_queue: short command queue between the front and the bit packer
// depends on hcbp_pkg
`default_nettype none

module hcbp_queue
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire hcbp_pkg::cmd_t           push_cmd,
    input  wire logic                     pop,
    output hcbp_pkg::cmd_t                head,
    output hcbp_pkg::queue_status_t       qstat
);

    hcbp_pkg::cmd_t                   slots [hcbp_pkg::QUEUE_DEPTH];
    logic [hcbp_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [hcbp_pkg::QUEUE_AW-1:0]    wr_ptr_next;
    logic [hcbp_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [hcbp_pkg::QUEUE_AW-1:0]    rd_ptr_next;
    logic [hcbp_pkg::QCNT_W-1:0]      count_reg;
    logic [hcbp_pkg::QCNT_W-1:0]      count_next;

    assign head        = slots[rd_ptr_reg];
    assign qstat.empty = (count_reg == '0);
    assign qstat.count = count_reg;

    // pointers wrap at the queue depth, which need not be a power of two
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == hcbp_pkg::QUEUE_DEPTH - 1)
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == hcbp_pkg::QUEUE_DEPTH - 1)
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hcbp_back.sv =====
// hcbp_back: bit packer, shifts code bits into bytes and drives the result channel
// depends on hcbp_pkg and hcbp_if
`default_nettype none

module hcbp_back
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire hcbp_pkg::cmd_t           head,
    input  wire hcbp_pkg::queue_status_t  qstat,
    output logic                          pop,
    hcbp_out_if.source                    results
);

    hcbp_pkg::pack_state_t            state_reg;
    hcbp_pkg::pack_state_t            state_next;
    logic [hcbp_pkg::CODE_W-1:0]      cw_reg;
    logic [hcbp_pkg::CODE_W-1:0]      cw_next;
    logic [hcbp_pkg::LEN_W-1:0]       rem_reg;
    logic [hcbp_pkg::LEN_W-1:0]       rem_next;
    logic [hcbp_pkg::BYTE_W-1:0]      pack_reg;
    logic [hcbp_pkg::BYTE_W-1:0]      pack_next;
    logic [hcbp_pkg::PAD_W-1:0]       nfree_reg;
    logic [hcbp_pkg::PAD_W-1:0]       nfree_next;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [hcbp_pkg::BYTE_W-1:0]      out_byte_reg;
    logic [hcbp_pkg::BYTE_W-1:0]      out_byte_next;
    logic [hcbp_pkg::PAD_W-1:0]       pad_reg;
    logic [hcbp_pkg::PAD_W-1:0]       pad_next;
    logic                             final_reg;
    logic                             final_next;
    logic                             last_reg;
    logic                             last_next;

    logic                             can_emit;
    logic                             held_full;
    logic [hcbp_pkg::PAD_W-1:0]       avail;
    logic [hcbp_pkg::BYTE_W-1:0]      base;
    logic [hcbp_pkg::PAD_W-1:0]       take;
    logic [hcbp_pkg::LEN_W-1:0]       rem_after;
    logic                             step_go;
    logic [hcbp_pkg::BYTE_W-1:0]      chunk;

    assign can_emit  = !out_valid_reg || results.ready;
    // no free bit left: the byte is full and waits for the next code bit or the finish
    assign held_full = (nfree_reg == '0);
    assign avail     = held_full ? hcbp_pkg::PAD_W'(hcbp_pkg::BYTE_W) : nfree_reg;
    assign base      = held_full ? '0 : pack_reg;
    assign take      = (rem_reg < hcbp_pkg::LEN_W'(avail)) ? rem_reg[hcbp_pkg::PAD_W-1:0]
                                                           : avail;
    assign rem_after = rem_reg - hcbp_pkg::LEN_W'(take);
    assign step_go   = (state_reg == hcbp_pkg::PK_ENCODE) && (!held_full || can_emit);
    assign chunk     = cw_reg[hcbp_pkg::CODE_W-1 -: hcbp_pkg::BYTE_W]
                       >> (hcbp_pkg::PAD_W'(hcbp_pkg::BYTE_W) - avail);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hcbp_pkg::PK_IDLE:
            begin
                if (!qstat.empty && (head.op == hcbp_pkg::OP_ENCODE) && (head.len != '0))
                begin
                    state_next = hcbp_pkg::PK_ENCODE;
                end
            end
            hcbp_pkg::PK_ENCODE:
            begin
                if (step_go && (rem_after == '0))
                begin
                    state_next = hcbp_pkg::PK_IDLE;
                end
            end
            default:
            begin
                state_next = hcbp_pkg::PK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        cw_next        = cw_reg;
        rem_next       = rem_reg;
        pack_next      = pack_reg;
        nfree_next     = nfree_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_byte_next  = out_byte_reg;
        pad_next       = pad_reg;
        final_next     = final_reg;
        last_next      = last_reg;
        case (state_reg)
            hcbp_pkg::PK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    if (head.op == hcbp_pkg::OP_FINISH)
                    begin
                        if (can_emit)
                        begin
                            pop            = 1'b1;
                            out_valid_next = 1'b1;
                            out_byte_next  = pack_reg;
                            pad_next       = nfree_reg;
                            final_next     = 1'b1;
                            last_next      = 1'b1;
                            pack_next      = '0;
                            nfree_next     = hcbp_pkg::PAD_W'(hcbp_pkg::BYTE_W);
                        end
                    end
                    else
                    begin
                        pop      = 1'b1;
                        cw_next  = head.word;
                        rem_next = head.len;
                    end
                end
            end
            hcbp_pkg::PK_ENCODE:
            begin
                if (step_go)
                begin
                    pack_next  = base | chunk;
                    nfree_next = avail - take;
                    rem_next   = rem_after;
                    cw_next    = cw_reg << take;
                    if (held_full)
                    begin
                        // a further code bit arrived, so the held full byte goes out
                        out_valid_next = 1'b1;
                        out_byte_next  = pack_reg;
                        pad_next       = '0;
                        final_next     = 1'b0;
                        last_next      = (rem_after == '0);
                    end
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cw_reg       <= cw_next;
        out_byte_reg <= out_byte_next;
        pad_reg      <= pad_next;
        final_reg    <= final_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hcbp_pkg::PK_IDLE;
            rem_reg       <= '0;
            pack_reg      <= '0;
            nfree_reg     <= hcbp_pkg::PAD_W'(hcbp_pkg::BYTE_W);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            pack_reg      <= pack_next;
            nfree_reg     <= nfree_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.out_byte     = out_byte_reg;
    assign results.padding_bits = pad_reg;
    assign results.is_final     = final_reg;
    assign results.last         = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/huffman_code_bit_packer.sv =====
// huffman_code_bit_packer: code table front, command queue and bit packer back
// depends on hcbp_pkg, hcbp_if, hcbp_front, hcbp_queue, hcbp_back
//
// items is a valid/ready sink: func 0 loads a code table entry, func 1 encodes
// a source byte, func 2 finishes the stream; func 3 is dropped
// results is a valid/ready source of packed bytes, earliest code bit in bit 7;
// last marks the final word that an item causes, is_final the finish word
// a load writes the table in place
// an encode reads the table on acceptance and enters the four-entry queue in
// the cycle after; the packer takes it from the queue when idle and packs its
// bits into bytes, up to eight bits and one byte word a cycle while no held
// full byte waits on a stalled receiver, and takes no new command until done
// an encode word passes the front register, the queue, the packer registers
// and the result register; a finish word skips the packer registers
// a full byte is held until the next code bit or the finish arrives
// items.ready falls once the queue and the command being read fill four slots;
// the queue absorbs receiver stalls, and a held result word stays steady
// reset empties the queue and the result register and leaves an empty byte
// with bit 7 next; the code table is not cleared and must be loaded first
`default_nettype none

module huffman_code_bit_packer
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    hcbp_in_if.sink    items,
    hcbp_out_if.source results
);

    logic                     push_valid;
    hcbp_pkg::cmd_t           push_cmd;
    logic                     pop;
    hcbp_pkg::cmd_t           head;
    hcbp_pkg::queue_status_t  qstat;

    hcbp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .qstat      (qstat),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    hcbp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    hcbp_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .qstat   (qstat),
        .pop     (pop),
        .results (results)
    );

endmodule

`default_nettype wire
